/* src/dsse_pkg.sv */
// Shared types, constants and helper functions for the decimal seven-segment encoder.
package dsse_pkg;

    localparam int DIGITS      = 4;
    localparam int DIG_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CMP_W       = 4;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;

    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic [15:0] number;
        logic        has_dot;
        logic [1:0]  dot_pos;
    } t_item;

    function automatic logic [7:0] font(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h3f;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5b;
            4'd3:    pat = 8'h4f;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6d;
            4'd6:    pat = 8'h7d;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7f;
            4'd9:    pat = 8'h6f;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

    // Exact for every 16-bit input: reciprocal multiply and shift.
    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(DIV10_MUL);
        return 16'(p >> DIV10_SHIFT);
    endfunction

endpackage

/* src/decimal_seven_segment_encoder_core.sv */
// Top level of the decimal seven-segment encoder: front queue plus digit sequencer.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_number,         | input
//           | i_dot_position                            |
//   out     | o_out_valid, i_out_ready, o_segments,     | output
//           | o_digit_index, o_last                     |
//
// Each number yields DIGITS result items, one per cycle unless the output
// stalls; the sequencer takes no new item until the last digit of the current
// one has been produced. The first digit is registered into the output register
// as the item is popped from the queue head. A two-entry queue lets input keep
// flowing while the output stalls. Synchronous active-low reset empties the queue
// and the output register; no clearing pass is needed.
module decimal_seven_segment_encoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [15:0]          i_number,
    input  logic signed [2:0]    i_dot_position,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_segments,
    output logic [1:0]           o_digit_index,
    output logic                 o_last
);
    import dsse_pkg::*;

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // Accept, classify the point position and queue the item.
    dsse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_number       (i_number),
        .i_dot_position (i_dot_position),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    // Pop one item, then advance one digit per cycle, while the output is not stalled, toward the output.
    dsse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_segments    (o_segments),
        .o_digit_index (o_digit_index),
        .o_last        (o_last)
    );

    // Pop only from a nonempty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Input stalls only when the queue holds items.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_valid)
        else $error("input stalled with empty queue");

    // A popped item produces its first digit in the next cycle.
    a_pop_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out_valid && (o_digit_index == 2'd0)))
        else $error("popped item produced no first digit");

endmodule

/* src/dsse_front.sv */
// Input stage: accepts items, classifies the decimal point and queues them.
module dsse_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [15:0]          i_number,
    input  logic signed [2:0]    i_dot_position,
    output logic                 o_q_valid,
    output dsse_pkg::t_item      o_q_item,
    input  logic                 i_q_pop
);
    import dsse_pkg::*;

    t_item                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 push;
    t_item                n_item;

    assign o_in_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_q[r_rptr];

    // Negative position means no point and no zero fill.
    always_comb begin
        n_item.number  = i_number;
        n_item.has_dot = ~i_dot_position[2];
        n_item.dot_pos = i_dot_position[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/dsse_back.sv */
// Digit sequencer: peels one decimal digit per cycle into the output register unless stalled.
module dsse_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  dsse_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_segments,
    output logic [1:0]           o_digit_index,
    output logic                 o_last
);
    import dsse_pkg::*;

    logic                 r_busy;
    logic [15:0]          r_rest;
    logic [DIG_W-1:0]     r_idx;
    logic                 r_has_dot;
    logic [1:0]           r_dot_pos;
    logic                 r_ovalid;
    logic [7:0]           r_seg;
    logic [1:0]           r_didx;
    logic                 r_last;

    logic                 adv;
    logic                 fire;
    logic [15:0]          cur_rest;
    logic [DIG_W-1:0]     cur_idx;
    logic                 cur_has_dot;
    logic [1:0]           cur_dot_pos;
    logic [15:0]          quo;
    logic [15:0]          rem;
    logic                 shown;
    logic                 is_last;
    logic [7:0]           pattern;

    assign adv     = !r_ovalid || i_out_ready;
    assign fire    = adv && (r_busy || i_q_valid);
    assign o_q_pop = adv && !r_busy && i_q_valid;

    // Digit 0 comes straight from the queue head; later digits from the held item.
    always_comb begin
        if (r_busy) begin
            cur_rest    = r_rest;
            cur_idx     = r_idx;
            cur_has_dot = r_has_dot;
            cur_dot_pos = r_dot_pos;
        end else begin
            cur_rest    = i_q_item.number;
            cur_idx     = '0;
            cur_has_dot = i_q_item.has_dot;
            cur_dot_pos = i_q_item.dot_pos;
        end
        quo     = div10(cur_rest);
        rem     = cur_rest - 16'((quo << 3) + (quo << 1));
        shown   = (cur_rest != '0) || (cur_idx == '0);
        is_last = (cur_idx == DIG_W'(DIGITS - 1));
        if (shown) begin
            pattern = font(rem[3:0]);
        end else if (cur_has_dot && (CMP_W'(cur_dot_pos) >= CMP_W'(cur_idx))) begin
            pattern = font(4'd0);
        end else begin
            pattern = SEG_BLANK;
        end
        if (cur_has_dot && (CMP_W'(cur_dot_pos) == CMP_W'(cur_idx))) begin
            pattern = pattern | SEG_DOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (fire) begin
                r_busy <= !is_last;
            end
            if (adv) begin
                r_ovalid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rest    <= quo;
            r_idx     <= is_last ? '0 : cur_idx + 1'b1;
            r_has_dot <= cur_has_dot;
            r_dot_pos <= cur_dot_pos;
            r_seg     <= ~pattern;
            r_didx    <= 2'(cur_idx);
            r_last    <= is_last;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_segments    = r_seg;
    assign o_digit_index = r_didx;
    assign o_last        = r_last;

endmodule
